[rtl/jddm_pkg.sv]
package jddm_pkg;

    // field and datapath widths
    localparam int SPEED_W    = 15;
    localparam int AXIS_W     = 16;
    localparam int DIVIDEND_W = 47;
    localparam int DIVISOR_W  = 32;
    localparam int DIV_CNT_W  = 6;
    localparam int RADICAND_W = 32;
    localparam int ROOT_W     = 16;
    localparam int SQRT_CNT_W = 5;

    // event kinds
    localparam logic [1:0] CMD_BUTTON = 2'd1;
    localparam logic [1:0] CMD_AXIS   = 2'd2;

    // button and axis numbers
    localparam logic [7:0] BTN_REVERSE  = 8'd0;
    localparam logic [7:0] BTN_SPIN_POS = 8'd1;
    localparam logic [7:0] BTN_SPIN_NEG = 8'd3;
    localparam logic [7:0] BTN_FORWARD  = 8'd4;
    localparam logic [7:0] AXIS_X       = 8'd2;
    localparam logic [7:0] AXIS_Y       = 8'd3;

    // configuration register indexes
    localparam logic REG_MAX_SPEED = 1'b0;
    localparam logic REG_MAX_STICK = 1'b1;

    // Q1.15 constants
    localparam logic [16:0] Q15_ONE   = 17'd32768;
    localparam logic [15:0] Q15_SQRT2 = 16'd46341;
    localparam logic [15:0] Q15_PI_4  = 16'd25736;
    localparam logic [15:0] Q15_PI_2  = 16'd51472;
    localparam logic [15:0] Q15_C0    = 16'd8018;
    localparam logic [15:0] Q15_C1    = 16'd2173;
    localparam logic signed [15:0] BUTTON_Y = 16'sd25000;

    // floor(2^31 / Q15_PI_2): estimate of a * 2^15 / Q15_PI_2, low by at most one
    localparam logic [15:0] Q15_PI_2_RECIP = 16'd41721;

    // divider request
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } div_ctl_t;

endpackage

[rtl/jddm_div.sv]
// Restoring divider, one quotient bit per cycle.
// The dividend comes left-aligned; count gives the number of quotient bits.
module jddm_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  jddm_pkg::div_ctl_t                  ctl,
    input  logic [jddm_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [jddm_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                done,
    output logic [jddm_pkg::DIVIDEND_W-1:0]     quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [jddm_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [jddm_pkg::DIVISOR_W-1:0]     rem_reg;
    logic [jddm_pkg::DIVIDEND_W-1:0]    dq_reg;
    logic [jddm_pkg::DIVISOR_W-1:0]     dvs_reg;

    logic [jddm_pkg::DIVISOR_W:0]       rem_sh;
    logic [jddm_pkg::DIVISOR_W:0]       rem_diff;
    logic                               fits;

    // one trial subtract
    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[jddm_pkg::DIVIDEND_W-1]};
        rem_diff = rem_sh - {1'b0, dvs_reg};
        fits     = (rem_sh >= {1'b0, dvs_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == jddm_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_diff[jddm_pkg::DIVISOR_W-1:0]
                            : rem_sh[jddm_pkg::DIVISOR_W-1:0];
            dq_reg  <= {dq_reg[jddm_pkg::DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

[rtl/jddm_isqrt.sv]
// Integer square root, one root bit per cycle (floor result).
module jddm_isqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [jddm_pkg::RADICAND_W-1:0]   radicand,
    output logic                              done,
    output logic [jddm_pkg::ROOT_W-1:0]       root
);

    localparam int REM_W = jddm_pkg::ROOT_W + 2;

    logic                                busy_reg;
    logic                                done_reg;
    logic [jddm_pkg::SQRT_CNT_W-1:0]     cnt_reg;
    logic [jddm_pkg::RADICAND_W-1:0]     v_reg;
    logic [REM_W-1:0]                    rem_reg;
    logic [jddm_pkg::ROOT_W-1:0]         root_reg;

    logic [REM_W+1:0]                    rem_sh;
    logic [REM_W+1:0]                    trial;
    logic [REM_W+1:0]                    diff;
    logic                                fits;

    // bring down two bits, try root*4+1
    always_comb
    begin
        rem_sh = {rem_reg, v_reg[jddm_pkg::RADICAND_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = rem_sh - trial;
        fits   = (rem_sh >= trial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= jddm_pkg::SQRT_CNT_W'(jddm_pkg::ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[jddm_pkg::RADICAND_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[jddm_pkg::ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[rtl/joystick_differential_drive_mixer.sv]
// Requests run through the sequencer: spinning goes straight to the result, straight drive
// uses a 30-step division, mixed drive a 16-step root, 46- and 31-step divisions on the
// shared divider, then multiplier steps on the shared multiplier.
// One request at a time: the next is taken the cycle after the result leaves; an output
// stall holds the result and with it the next request.
// Reset (rst_n low, asynchronous) clears stick and spin state, speed limit 127, stick 32767.
module joystick_differential_drive_mixer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [14:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [7:0]         event_number,
    input  logic signed [15:0] event_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left_speed,
    output logic signed [15:0] right_speed
);

    typedef enum logic [24:0] {
        ST_IDLE      = 25'h0000001,
        ST_CHECK     = 25'h0000002,
        ST_STR_DIV   = 25'h0000004,
        ST_STR_WAIT  = 25'h0000008,
        ST_SQ_A      = 25'h0000010,
        ST_SQ_B      = 25'h0000020,
        ST_SQRT_WAIT = 25'h0000040,
        ST_MAG_M1    = 25'h0000080,
        ST_MAG_M2    = 25'h0000100,
        ST_MAG_DIV   = 25'h0000200,
        ST_MAG_WAIT  = 25'h0000400,
        ST_T_DIV     = 25'h0000800,
        ST_T_WAIT    = 25'h0001000,
        ST_P1        = 25'h0002000,
        ST_P2        = 25'h0004000,
        ST_P3        = 25'h0008000,
        ST_P4        = 25'h0010000,
        ST_P5        = 25'h0020000,
        ST_F_MUL     = 25'h0040000,
        ST_F_EST     = 25'h0080000,
        ST_O_MUL     = 25'h0100000,
        ST_O_RES     = 25'h0200000,
        ST_OUT       = 25'h0400000,
        ST_F_FIX     = 25'h0800000,
        ST_SPARE_B   = 25'h1000000
    } state_t;

    state_t state_reg, state_next;

    logic [14:0]        speed_reg;
    logic [14:0]        stick_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic [1:0]         spin_reg;

    logic [31:0]        prod_reg;
    logic [31:0]        sq_reg;
    logic [30:0]        num_reg;
    logic [14:0]        mag_reg;
    logic [15:0]        t_reg;
    logic [15:0]        poly_reg;
    logic [15:0]        quad_reg;
    logic [16:0]        a_reg;
    logic [15:0]        f_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;

    logic [14:0] s_eff;
    logic [14:0] m_eff;
    logic [16:0] x_neg;
    logic [16:0] y_neg;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [16:0] one_minus_t;
    logic [16:0] a_sum;
    logic [16:0] a_refl;
    logic [15:0] q15_s;
    logic [14:0] div_cap;
    logic [31:0] f_rem;
    logic        accept;
    logic        pressed;

    jddm_pkg::div_ctl_t                    div_ctl;
    logic [jddm_pkg::DIVIDEND_W-1:0]       div_dividend;
    logic [jddm_pkg::DIVISOR_W-1:0]        div_divisor;
    logic                                  div_done;
    logic [jddm_pkg::DIVIDEND_W-1:0]       div_q;
    logic                                  sqrt_start;
    logic                                  sqrt_done;
    logic [jddm_pkg::ROOT_W-1:0]           sqrt_root;

    // operand preparation
    always_comb
    begin
        s_eff       = (speed_reg == '0) ? 15'd1 : speed_reg;
        m_eff       = (stick_reg == '0) ? 15'd1 : stick_reg;
        x_neg       = 17'd0 - {x_reg[15], x_reg};
        y_neg       = 17'd0 - {y_reg[15], y_reg};
        ax          = x_reg[15] ? x_neg[15:0] : x_reg;
        ay          = y_reg[15] ? y_neg[15:0] : y_reg;
        lo          = (ax < ay) ? ax : ay;
        hi          = (ax < ay) ? ay : ax;
        one_minus_t = jddm_pkg::Q15_ONE - {1'b0, t_reg};
        a_sum       = a_reg + prod_reg[31:15];
        a_refl      = (a_sum > {1'b0, jddm_pkg::Q15_PI_2}) ? 17'd0
                                                          : {1'b0, jddm_pkg::Q15_PI_2} - a_sum;
        q15_s       = {1'b0, s_eff};
        div_cap     = (div_q > {32'd0, s_eff}) ? s_eff : div_q[14:0];
        // what is left of a * 2^15 after the estimated fraction times pi/2
        f_rem       = {a_reg, 15'd0} - prod_reg;
        accept      = in_valid && !in_stall;
        pressed     = (event_value != '0);
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_CHECK:
            begin
                mul_a = (x_reg == '0) ? ay : ax;
                mul_b = (x_reg == '0) ? q15_s : ax;
            end
            ST_SQ_A:
            begin
                mul_a = ay;
                mul_b = ay;
            end
            ST_MAG_M1:
            begin
                mul_a = sqrt_root;
                mul_b = q15_s;
            end
            ST_MAG_M2:
            begin
                mul_a = jddm_pkg::Q15_SQRT2;
                mul_b = {1'b0, m_eff};
            end
            ST_P1:
            begin
                mul_a = jddm_pkg::Q15_C1;
                mul_b = t_reg;
            end
            ST_P2:
            begin
                mul_a = t_reg;
                mul_b = one_minus_t[15:0];
            end
            ST_P3:
            begin
                mul_a = jddm_pkg::Q15_PI_4;
                mul_b = t_reg;
            end
            ST_P4:
            begin
                mul_a = quad_reg;
                mul_b = poly_reg;
            end
            ST_F_MUL:
            begin
                mul_a = a_reg[15:0];
                mul_b = jddm_pkg::Q15_PI_2_RECIP;
            end
            ST_F_EST:
            begin
                mul_a = prod_reg[31:16];
                mul_b = jddm_pkg::Q15_PI_2;
            end
            ST_O_MUL:
            begin
                mul_a = {1'b0, mag_reg};
                mul_b = f_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider and root requests
    always_comb
    begin
        div_ctl.start = 1'b0;
        div_ctl.count = '0;
        div_dividend  = '0;
        div_divisor   = '0;
        sqrt_start    = (state_reg == ST_SQ_B);
        case (state_reg)
            ST_STR_DIV:
            begin
                div_ctl.start = 1'b1;
                div_ctl.count = jddm_pkg::DIV_CNT_W'(30);
                div_dividend  = {prod_reg[29:0], 17'd0};
                div_divisor   = {17'd0, m_eff};
            end
            ST_MAG_DIV:
            begin
                div_ctl.start = 1'b1;
                div_ctl.count = jddm_pkg::DIV_CNT_W'(46);
                div_dividend  = {num_reg, 16'd0};
                div_divisor   = prod_reg;
            end
            ST_T_DIV:
            begin
                div_ctl.start = 1'b1;
                div_ctl.count = jddm_pkg::DIV_CNT_W'(31);
                div_dividend  = {lo, 31'd0};
                div_divisor   = {16'd0, hi};
            end
            default:
            begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (spin_reg != 2'b00)
                    state_next = ST_OUT;
                else if (x_reg == '0)
                    state_next = ST_STR_DIV;
                else
                    state_next = ST_SQ_A;
            end
            ST_STR_DIV:   state_next = ST_STR_WAIT;
            ST_STR_WAIT:  if (div_done) state_next = ST_OUT;
            ST_SQ_A:      state_next = ST_SQ_B;
            ST_SQ_B:      state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (sqrt_done) state_next = ST_MAG_M1;
            ST_MAG_M1:    state_next = ST_MAG_M2;
            ST_MAG_M2:    state_next = ST_MAG_DIV;
            ST_MAG_DIV:   state_next = ST_MAG_WAIT;
            ST_MAG_WAIT:  if (div_done) state_next = ST_T_DIV;
            ST_T_DIV:     state_next = ST_T_WAIT;
            ST_T_WAIT:    if (div_done) state_next = ST_P1;
            ST_P1:        state_next = ST_P2;
            ST_P2:        state_next = ST_P3;
            ST_P3:        state_next = ST_P4;
            ST_P4:        state_next = ST_P5;
            ST_P5:        state_next = ST_F_MUL;
            ST_F_MUL:     state_next = ST_F_EST;
            ST_F_EST:     state_next = ST_F_FIX;
            ST_F_FIX:     state_next = ST_O_MUL;
            ST_O_MUL:     state_next = ST_O_RES;
            ST_O_RES:     state_next = ST_OUT;
            ST_OUT:       if (!out_stall) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control state, configuration and stick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            speed_reg <= 15'd127;
            stick_reg <= 15'd32767;
            x_reg     <= '0;
            y_reg     <= '0;
            spin_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (cfg_index == jddm_pkg::REG_MAX_SPEED)
                    speed_reg <= cfg_data;
                else
                    stick_reg <= cfg_data;
            end
            // event decode
            if (accept)
            begin
                if (command == jddm_pkg::CMD_BUTTON)
                begin
                    if (event_number == jddm_pkg::BTN_SPIN_POS)
                        spin_reg <= pressed ? 2'b01 : 2'b00;
                    if (event_number == jddm_pkg::BTN_SPIN_NEG)
                        spin_reg <= pressed ? 2'b11 : 2'b00;
                    if (event_number == jddm_pkg::BTN_FORWARD)
                        y_reg <= pressed ? jddm_pkg::BUTTON_Y : 16'sd0;
                    if (event_number == jddm_pkg::BTN_REVERSE)
                        y_reg <= pressed ? -jddm_pkg::BUTTON_Y : 16'sd0;
                end
                else if (command == jddm_pkg::CMD_AXIS)
                begin
                    if (event_number == jddm_pkg::AXIS_X)
                        x_reg <= event_value;
                    if (event_number == jddm_pkg::AXIS_Y)
                        y_reg <= (event_value == 16'sh8000) ? 16'sh7fff : -event_value;
                end
            end
        end
    end

    // arithmetic datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_CHECK:
            begin
                // spin drives both motors at minus spin times max speed
                if (spin_reg[1])
                begin
                    left_reg  <= {1'b0, s_eff};
                    right_reg <= {1'b0, s_eff};
                end
                else
                begin
                    left_reg  <= -$signed({1'b0, s_eff});
                    right_reg <= -$signed({1'b0, s_eff});
                end
            end
            ST_STR_WAIT:
            begin
                if (div_done)
                begin
                    if (y_reg > 16'sd0)
                    begin
                        left_reg  <= -$signed({1'b0, div_cap});
                        right_reg <= {1'b0, div_cap};
                    end
                    else
                    begin
                        left_reg  <= {1'b0, div_cap};
                        right_reg <= -$signed({1'b0, div_cap});
                    end
                end
            end
            ST_SQ_A:
                sq_reg <= prod_reg;
            ST_MAG_M2:
                num_reg <= prod_reg[30:0];
            ST_MAG_WAIT:
            begin
                if (div_done)
                    mag_reg <= div_cap;
            end
            ST_T_WAIT:
            begin
                if (div_done)
                    t_reg <= div_q[15:0];
            end
            ST_P2:
                poly_reg <= jddm_pkg::Q15_C0 + prod_reg[30:15];
            ST_P3:
                quad_reg <= prod_reg[30:15];
            ST_P4:
                a_reg <= prod_reg[31:15];
            ST_P5:
                a_reg <= (ay > ax) ? a_refl : a_sum;
            ST_F_EST:
                f_reg <= prod_reg[31:16];
            ST_F_FIX:
            begin
                // the estimate is at most one low
                if (f_rem >= {16'd0, jddm_pkg::Q15_PI_2})
                    f_reg <= f_reg + 16'd1;
            end
            ST_O_RES:
            begin
                // quadrant selects which motor gets magnitude and which the angle share
                if (!x_reg[15])
                begin
                    if (!y_reg[15])
                    begin
                        left_reg  <= -$signed({1'b0, mag_reg});
                        right_reg <= {1'b0, prod_reg[29:15]};
                    end
                    else
                    begin
                        left_reg  <= {1'b0, mag_reg};
                        right_reg <= -$signed({1'b0, prod_reg[29:15]});
                    end
                end
                else
                begin
                    if (!y_reg[15])
                    begin
                        left_reg  <= -$signed({1'b0, prod_reg[29:15]});
                        right_reg <= {1'b0, mag_reg};
                    end
                    else
                    begin
                        left_reg  <= {1'b0, prod_reg[29:15]};
                        right_reg <= -$signed({1'b0, mag_reg});
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    jddm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    jddm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_reg + prod_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign left_speed  = left_reg;
    assign right_speed = right_reg;

endmodule

[dv/tb_joystick_differential_drive_mixer.sv]
module tb_joystick_differential_drive_mixer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_OTHER = 2'd0;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic               cfg_index;
    logic [14:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         command;
    logic [7:0]         event_number;
    logic signed [15:0] event_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;

    // predictor state and register copies
    int unsigned        speed_cap;
    int unsigned        stick_full;
    int                 pos_x;
    int                 pos_y;
    int                 spin;
    logic [15:0]        left_q[$];
    logic [15:0]        right_q[$];
    int                 errors;
    bit                 hold_off;
    int                 stall_pct;

    joystick_differential_drive_mixer DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .event_number(event_number), .event_value(event_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .left_speed(left_speed), .right_speed(right_speed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("FAILURE");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic int clamp_speed(int v, int s);
        if (v > s) return s;
        if (v < -s) return -s;
        return v;
    endfunction

    // update stick state, then mix into the expected motor pair
    task automatic predict_speeds(logic [1:0] cmd, logic [7:0] num, logic signed [15:0] val);
        longint unsigned s, m, ax, ay, r, mag, lo, hi, t, poly, quad, a, f, o;
        int lft, rgt, v, qi;
        bit pressed;
        pressed = (val != 0);
        if (cmd == jddm_pkg::CMD_BUTTON)
        begin
            if (num == jddm_pkg::BTN_SPIN_POS) spin = pressed ? 1 : 0;
            if (num == jddm_pkg::BTN_SPIN_NEG) spin = pressed ? -1 : 0;
            if (num == jddm_pkg::BTN_FORWARD) pos_y = pressed ? 25000 : 0;
            if (num == jddm_pkg::BTN_REVERSE) pos_y = pressed ? -25000 : 0;
        end
        else if (cmd == jddm_pkg::CMD_AXIS)
        begin
            if (num == jddm_pkg::AXIS_X) pos_x = val;
            if (num == jddm_pkg::AXIS_Y) pos_y = (val == 16'sh8000) ? 32767 : -int'(val);
        end
        s = (speed_cap != 0) ? speed_cap : 1;
        m = (stick_full != 0) ? stick_full : 1;
        ax = (pos_x < 0) ? -pos_x : pos_x;
        ay = (pos_y < 0) ? -pos_y : pos_y;
        if (spin != 0)
        begin
            v = clamp_speed(-spin * int'(s), int'(s));
            lft = v;
            rgt = v;
        end
        else if (pos_x == 0)
        begin
            qi = int'((ay * s / m > s) ? s : ay * s / m);
            lft = (pos_y > 0) ? -qi : qi;
            rgt = (pos_y > 0) ? qi : -qi;
        end
        else
        begin
            r = int_sqrt(ax * ax + ay * ay);
            mag = r * s * 32768 / (46341 * m);
            lo = (ax < ay) ? ax : ay;
            hi = (ax < ay) ? ay : ax;
            t = lo * 32768 / hi;
            poly = 8018 + ((2173 * t) >> 15);
            quad = (t * (32768 - t)) >> 15;
            a = ((25736 * t) >> 15) + ((quad * poly) >> 15);
            if (ay > ax) a = (a > 51472) ? 0 : 51472 - a;
            f = a * 32768 / 51472;
            if (f > 32768) f = 32768;
            if (mag > s) mag = s;
            o = (mag * f) >> 15;
            if (pos_x > 0)
            begin
                if (pos_y >= 0) begin lft = -int'(mag); rgt = int'(o); end
                else begin lft = int'(mag); rgt = -int'(o); end
            end
            else
            begin
                if (pos_y >= 0) begin lft = -int'(o); rgt = int'(mag); end
                else begin lft = int'(o); rgt = -int'(mag); end
            end
        end
        left_q.push_back(lft[15:0]);
        right_q.push_back(rgt[15:0]);
    endtask

    // send one request; burst gaps are random, valid stays up into the next request
    task automatic send_event(logic [1:0] cmd, logic [7:0] num, logic signed [15:0] val);
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        event_number <= num;
        event_value <= val;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_speeds(cmd, num, val);
    endtask

    // stop sending and wait for all results, plus the mixed-drive latency
    task automatic drain;
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (left_q.size() != 0 && n < 100000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [14:0] val);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == jddm_pkg::REG_MAX_SPEED) speed_cap = val;
        else stick_full = val;
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 7))
            0: return 16'sd32767;
            1: return -16'sd32767;
            2: return 16'sh8000;
            3: return 16'sd0;
            4: return 16'(int'($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    // compare each result with the oldest expectation
    initial
    begin
        logic [15:0] el, er;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (left_q.size() == 0)
                begin
                    $display("%0t: unexpected result %0d %0d", $time, left_speed, right_speed);
                    errors++;
                end
                else
                begin
                    el = left_q.pop_front();
                    er = right_q.pop_front();
                    if (left_speed !== el)
                    begin
                        $display("%0t: left_speed expected %0d actual %0d",
                                 $time, $signed(el), left_speed);
                        errors++;
                    end
                    if (right_speed !== er)
                    begin
                        $display("%0t: right_speed expected %0d actual %0d",
                                 $time, $signed(er), right_speed);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic test_buttons;
        send_event(jddm_pkg::CMD_BUTTON, jddm_pkg::BTN_FORWARD, 16'sd1);
        send_event(jddm_pkg::CMD_BUTTON, jddm_pkg::BTN_FORWARD, 16'sd0);
        send_event(jddm_pkg::CMD_BUTTON, jddm_pkg::BTN_REVERSE, -16'sd5);
        send_event(jddm_pkg::CMD_BUTTON, jddm_pkg::BTN_SPIN_POS, 16'sd1);
        send_event(jddm_pkg::CMD_BUTTON, jddm_pkg::BTN_SPIN_POS, 16'sd0);
        send_event(jddm_pkg::CMD_BUTTON, jddm_pkg::BTN_SPIN_NEG, 16'sd7);
        send_event(jddm_pkg::CMD_BUTTON, jddm_pkg::BTN_SPIN_NEG, 16'sd0);
        send_event(jddm_pkg::CMD_BUTTON, 8'd255, 16'sd1);
        send_event(CMD_OTHER, jddm_pkg::AXIS_X, 16'sd100);
        send_event(CMD_SPARE, jddm_pkg::AXIS_X, 16'sd100);
    endtask

    task automatic test_axes;
        send_event(jddm_pkg::CMD_AXIS, jddm_pkg::AXIS_Y, 16'sh8000);
        send_event(jddm_pkg::CMD_AXIS, jddm_pkg::AXIS_X, 16'sd32767);
        send_event(jddm_pkg::CMD_AXIS, jddm_pkg::AXIS_Y, 16'sd32767);
        send_event(jddm_pkg::CMD_AXIS, jddm_pkg::AXIS_X, -16'sd32767);
        send_event(jddm_pkg::CMD_AXIS, jddm_pkg::AXIS_Y, -16'sd32767);
        send_event(jddm_pkg::CMD_AXIS, jddm_pkg::AXIS_X, 16'sh8000);
        send_event(jddm_pkg::CMD_AXIS, jddm_pkg::AXIS_Y, 16'sd1);
        send_event(jddm_pkg::CMD_AXIS, jddm_pkg::AXIS_X, 16'sd1);
        send_event(jddm_pkg::CMD_AXIS, jddm_pkg::AXIS_Y, 16'sd0);
        send_event(jddm_pkg::CMD_AXIS, 8'd200, 16'sd5);
        send_event(jddm_pkg::CMD_AXIS, jddm_pkg::AXIS_X, 16'sd0);
    endtask

    task automatic test_random(int count);
        logic [1:0] cmd;
        logic [7:0] num;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                cmd = 2'($urandom);
                num = 8'($urandom);
                send_event(cmd, num, 16'($urandom));
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: num = jddm_pkg::BTN_REVERSE;
                    1: num = jddm_pkg::BTN_SPIN_POS;
                    2: num = jddm_pkg::BTN_SPIN_NEG;
                    default: num = jddm_pkg::BTN_FORWARD;
                endcase
                send_event(jddm_pkg::CMD_BUTTON, num,
                           ($urandom_range(0, 1) != 0) ? rand_axis() : 16'sd0);
            end
            else
                send_event(jddm_pkg::CMD_AXIS,
                           $urandom_range(0, 1) ? jddm_pkg::AXIS_X : jddm_pkg::AXIS_Y,
                           rand_axis());
        end
    endtask

    task automatic test_backpressure;
        hold_off = 1'b1;
        test_random(20);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = jddm_pkg::REG_MAX_SPEED;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_OTHER;
        event_number = '0;
        event_value = '0;
        errors = 0;
        hold_off = 1'b0;
        stall_pct = 0;
        speed_cap = 127;
        stick_full = 32767;
        pos_x = 0;
        pos_y = 0;
        spin = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_buttons();
        test_axes();
        stall_pct = 30;
        test_random(300);
        test_backpressure();
        write_reg(jddm_pkg::REG_MAX_SPEED, 15'd32767);
        write_reg(jddm_pkg::REG_MAX_STICK, 15'd1);
        test_random(200);
        write_reg(jddm_pkg::REG_MAX_SPEED, 15'd1);
        write_reg(jddm_pkg::REG_MAX_STICK, 15'd32767);
        stall_pct = 0;
        test_random(200);
        write_reg(jddm_pkg::REG_MAX_SPEED, 15'd0);
        write_reg(jddm_pkg::REG_MAX_STICK, 15'd0);
        test_random(100);
        stall_pct = 60;
        write_reg(jddm_pkg::REG_MAX_SPEED, 15'd1000);
        write_reg(jddm_pkg::REG_MAX_STICK, 15'd20000);
        test_random(300);
        stall_pct = 20;
        write_reg(jddm_pkg::REG_MAX_SPEED, 15'($urandom));
        write_reg(jddm_pkg::REG_MAX_STICK, 15'($urandom));
        test_random(280);
        drain();

        if (errors == 0 && left_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[sim.f]
rtl/jddm_pkg.sv
rtl/jddm_div.sv
rtl/jddm_isqrt.sv
rtl/joystick_differential_drive_mixer.sv
dv/tb_joystick_differential_drive_mixer.sv
